// ===== hdl/sg3_pkg.sv =====
// Shared constants and types of the 3x3 Sobel gradient block.
package sg3_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIXEL_W        = 9;
  localparam int GRAD_W         = 12;
  localparam int CENTER_ROW_W   = 12;
  localparam int CENTER_COL_W   = 11;
  localparam int IMAGE_WIDTH_W  = 12;
  localparam int IMAGE_HEIGHT_W = 13;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 13;

  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int MIN_DIM        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Control handed from the scan stage to the window stage.
  typedef struct packed {
    logic adv;      // stage-one item moves on this cycle
    logic produce;  // item completes a window (row and column at least 2)
    logic last;     // item is the last pixel of the frame
  } sg3_step_t;

endpackage

// ===== hdl/sg3_line_store.sv =====
// Two line stores holding the previous two rows, one synchronous read port each.
module sg3_line_store import sg3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr_i,
  input  logic [PIXEL_W-1:0]            wr_pixel_i,
  output logic [PIXEL_W-1:0]            top_o,
  output logic [PIXEL_W-1:0]            mid_o
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [PIXEL_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] middle_mem[MAX_WIDTH];
  logic [PIXEL_W-1:0] top_q;
  logic [PIXEL_W-1:0] mid_q;

  // The middle row sample read for this item moves up; the new sample becomes
  // the middle row. Consecutive items never share a column.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= mid_q;
      middle_mem[wr_addr_i] <= wr_pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      top_q <= upper_mem[rd_addr_i[AW-1:0]];
      mid_q <= middle_mem[rd_addr_i[AW-1:0]];
    end
  end

  assign top_o = top_q;
  assign mid_o = mid_q;

endmodule

// ===== hdl/sg3_window.sv =====
// Window columns, gradient arithmetic and the result register.
module sg3_window import sg3_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sg3_step_t                      step_i,
  input  logic [PIXEL_W-1:0]             pixel_i,
  input  logic [PIXEL_W-1:0]             top_i,
  input  logic [PIXEL_W-1:0]             mid_i,
  input  logic [CENTER_ROW_W-1:0]        center_row_i,
  input  logic [CENTER_COL_W-1:0]        center_col_i,
  input  logic                           out_stall_i,
  output logic                           out_free_o,
  output logic                           out_valid_o,
  output logic signed [GRAD_W-1:0]       grad_x_o,
  output logic signed [GRAD_W-1:0]       grad_y_o,
  output logic [CENTER_ROW_W-1:0]        center_row_o,
  output logic [CENTER_COL_W-1:0]        center_col_o,
  output logic                           frame_last_o
);

  // Two previous columns; the middle sample of the nearer one has weight zero.
  logic [PIXEL_W-1:0] tl_q, ml_q, bl_q, tc_q, bc_q;
  // The nearer column's middle sample is only needed once it becomes the
  // farther column, so it is kept in a register of its own.
  logic [PIXEL_W-1:0] mc_q;
  logic [GRAD_W-1:0]  left_sum, right_sum, top_sum, bot_sum;
  logic signed [GRAD_W-1:0] gx_d, gy_d;

  logic                      valid_q;
  logic signed [GRAD_W-1:0]  gx_q, gy_q;
  logic [CENTER_ROW_W-1:0]   row_q;
  logic [CENTER_COL_W-1:0]   col_q;
  logic                      last_q;

  always_comb begin
    left_sum  = GRAD_W'(tl_q) + (GRAD_W'(ml_q) << 1) + GRAD_W'(bl_q);
    right_sum = GRAD_W'(top_i) + (GRAD_W'(mid_i) << 1) + GRAD_W'(pixel_i);
    top_sum   = GRAD_W'(tl_q) + (GRAD_W'(tc_q) << 1) + GRAD_W'(top_i);
    bot_sum   = GRAD_W'(bl_q) + (GRAD_W'(bc_q) << 1) + GRAD_W'(pixel_i);
    gx_d      = signed'(left_sum - right_sum);
    gy_d      = signed'(top_sum - bot_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tl_q <= '0;
      ml_q <= '0;
      bl_q <= '0;
      tc_q <= '0;
      bc_q <= '0;
    end else if (step_i.adv) begin
      tl_q <= tc_q;
      ml_q <= mc_q;
      bl_q <= bc_q;
      tc_q <= top_i;
      bc_q <= pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q <= '0;
    end else if (step_i.adv) begin
      mc_q <= mid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step_i.adv && step_i.produce) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.adv && step_i.produce) begin
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      row_q  <= center_row_i;
      col_q  <= center_col_i;
      last_q <= step_i.last;
    end
  end

  assign out_free_o   = !valid_q || !out_stall_i;
  assign out_valid_o  = valid_q;
  assign grad_x_o     = gx_q;
  assign grad_y_o     = gy_q;
  assign center_row_o = row_q;
  assign center_col_o = col_q;
  assign frame_last_o = last_q;

endmodule

// ===== hdl/sobel_gradient_3x3.sv =====
// Top level of the streaming 3x3 Sobel gradient block.
//
//   Channel  Direction  Handshake                   Payload
//   in       sink       in_valid_i / in_stall_o     pixel_level_i
//   out      source     out_valid_o / out_stall_i   grad_x_o, grad_y_o, center_row_o,
//                                                   center_col_o, frame_last_o
//   cfg      sink       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item is taken per cycle unless in_stall_o is high. Accepting an item registers it
// and its line-store reads in stage one; the gradient is loaded into the result register
// when the item leaves stage one, which a stalled result can hold back.
// Reset clears counters, window and valids; the line stores need no clearing.
// A stalled result holds the window stage, which in turn stalls the input.
module sobel_gradient_3x3 import sg3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [PIXEL_W-1:0]          pixel_level_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [GRAD_W-1:0]    grad_x_o,
  output logic signed [GRAD_W-1:0]    grad_y_o,
  output logic [CENTER_ROW_W-1:0]     center_row_o,
  output logic [CENTER_COL_W-1:0]     center_col_o,
  output logic                        frame_last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int WRST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int HRST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [WW-1:0] w_eff_q;
  logic [HW-1:0] h_eff_q;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic               s1_valid_q;
  logic [PIXEL_W-1:0] s1_px_q;
  logic [CW-1:0]      s1_col_q;
  logic [RW-1:0]      s1_row_q;

  logic               accept;
  logic               col_wrap, row_wrap;
  logic               out_free;
  sg3_step_t          step;
  logic [PIXEL_W-1:0] top_px, mid_px;
  logic [CENTER_ROW_W-1:0] center_row;
  logic [CENTER_COL_W-1:0] center_col;

  // Configuration: values are kept already clamped to the legal range.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q <= WW'(WRST);
      h_eff_q <= HW'(HRST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          if (int'(cfg_data_i[IMAGE_WIDTH_W-1:0]) < MIN_DIM) begin
            w_eff_q <= WW'(MIN_DIM);
          end else if (int'(cfg_data_i[IMAGE_WIDTH_W-1:0]) > MAX_WIDTH) begin
            w_eff_q <= WW'(MAX_WIDTH);
          end else begin
            w_eff_q <= WW'(cfg_data_i[IMAGE_WIDTH_W-1:0]);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (int'(cfg_data_i[IMAGE_HEIGHT_W-1:0]) < MIN_DIM) begin
            h_eff_q <= HW'(MIN_DIM);
          end else if (int'(cfg_data_i[IMAGE_HEIGHT_W-1:0]) > MAX_HEIGHT) begin
            h_eff_q <= HW'(MAX_HEIGHT);
          end else begin
            h_eff_q <= HW'(cfg_data_i[IMAGE_HEIGHT_W-1:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Scan counters advance as each item is accepted.
  always_comb begin
    col_wrap = (WW'(col_q) + WW'(1)) >= w_eff_q;
    row_wrap = (HW'(row_q) + HW'(1)) >= h_eff_q;
    col_d    = col_wrap ? '0 : col_q + CW'(1);
    row_d    = row_q;
    if (col_wrap) begin
      row_d = row_wrap ? '0 : row_q + RW'(1);
    end
  end

  always_comb begin
    step.produce = (s1_row_q >= RW'(2)) && (s1_col_q >= CW'(2));
    step.last    = ((HW'(s1_row_q) + HW'(1)) == h_eff_q) &&
                   ((WW'(s1_col_q) + WW'(1)) == w_eff_q);
    step.adv     = s1_valid_q && (!step.produce || out_free);
  end

  assign in_stall_o = s1_valid_q && !step.adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign center_row = CENTER_ROW_W'(s1_row_q - RW'(1));
  assign center_col = CENTER_COL_W'(s1_col_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        s1_valid_q <= 1'b1;
      end else if (step.adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q  <= pixel_level_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  sg3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (col_q),
    .wr_en_i    (step.adv),
    .wr_addr_i  (s1_col_q),
    .wr_pixel_i (s1_px_q),
    .top_o      (top_px),
    .mid_o      (mid_px)
  );

  sg3_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .pixel_i      (s1_px_q),
    .top_i        (top_px),
    .mid_i        (mid_px),
    .center_row_i (center_row),
    .center_col_i (center_col),
    .out_stall_i  (out_stall_i),
    .out_free_o   (out_free),
    .out_valid_o  (out_valid_o),
    .grad_x_o     (grad_x_o),
    .grad_y_o     (grad_y_o),
    .center_row_o (center_row_o),
    .center_col_o (center_col_o),
    .frame_last_o (frame_last_o)
  );

endmodule
